// File: sv/assert_macros.svh
// Assertion helpers for the weighted score replacement block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define WSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define WSC_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// File: sv/wsc_pkg.sv
package wsc_pkg;

    localparam int NUM_SETS      = 2048;
    localparam int NUM_WAYS      = 16;
    localparam int HIST_DEPTH    = 8;
    localparam int REUSE_ENTRIES = 2048;
    localparam int ADDR_BITS     = 48;
    localparam int STAMP_BITS    = 32;
    localparam int SCORE_BITS    = 48;
    localparam int CNT_W         = 4;

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int HIST_W    = $clog2(HIST_DEPTH);
    localparam int FILL_W    = $clog2(HIST_DEPTH + 1);
    localparam int REUSE_W   = $clog2(REUSE_ENTRIES);
    localparam int BLK_W     = SET_W + WAY_W;
    localparam int HADDR_W   = SET_W + HIST_W;
    localparam int LOAD_N    = (NUM_WAYS > HIST_DEPTH) ? NUM_WAYS : HIST_DEPTH;
    localparam int LOAD_CW   = $clog2(LOAD_N + 1);
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_AGE   = 3'd0,
        CFG_WEIGHT_HITS  = 3'd1,
        CFG_WEIGHT_DIST  = 3'd2,
        CFG_WEIGHT_REUSE = 3'd3,
        CFG_COUNT_CAP    = 3'd4,
        CFG_LINE_SHIFT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                 mode;
        logic [10:0]          set_index;
        logic [3:0]           way_index;
        logic [47:0]          phys_addr;
        logic [47:0]          program_counter;
        logic                 was_hit;
    } t_in_item;

    typedef struct packed {
        logic [3:0]           evict_way;
        logic [47:0]          victim_score;
    } t_out_item;

    typedef struct packed {
        logic [STAMP_BITS-1:0] stamp;
        logic [CNT_W-1:0]      hits;
        logic [ADDR_BITS-1:0]  pc;
        logic [ADDR_BITS-1:0]  addr;
    } t_blk;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [HIST_W-1:0] head;
    } t_meta;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_BITS-1:0]  tag;
        logic [CNT_W-1:0]      score;
        logic [STAMP_BITS-1:0] stamp;
    } t_reuse_ent;

    typedef enum logic {
        ALU_DIST = 1'b0,
        ALU_MAC  = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op               op;
        logic [SCORE_BITS-1:0] a;
        logic [SCORE_BITS-1:0] b;
        logic [CNT_W-1:0]      w;
        logic [SCORE_BITS-1:0] acc;
    } t_alu_req;

    typedef struct packed {
        logic                  clear;
        logic [REUSE_W-1:0]    clr_idx;
        logic                  lookup;
        logic                  train;
        logic                  hit;
        logic [ADDR_BITS-1:0]  pc;
        logic [STAMP_BITS-1:0] clock;
        logic [CNT_W-1:0]      cap;
    } t_reuse_req;

    typedef struct packed {
        logic done;
    } t_reuse_rsp;

    function automatic logic [CNT_W-1:0] cap_minus(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] cap);
        return (v >= cap) ? '0 : cap - v;
    endfunction

    function automatic logic [CNT_W-1:0] hit_step(input logic [CNT_W-1:0] v,
                                                  input logic hit,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (hit) begin
            res = (v >= cap) ? cap : v + 1'b1;
        end else begin
            res = (v == '0) ? '0 : v - 1'b1;
        end
        return res;
    endfunction

endpackage

// File: sv/weighted_score_cache_replacement_top.sv
// Victim request: load of ways and history, push into the ring, reuse-table scan, then
// scoring per way. Block update: block write, then a one-entry-a-cycle reuse-table scan.
// One item at a time; the result register lets the next item in while a result waits.
// Reset: synchronous, active low; a clearing pass zeroes block, set and reuse state,
// during which no item is accepted (configuration writes are taken).
`include "assert_macros.svh"

module weighted_score_cache_replacement_top import wsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_wdata
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_LOAD   = 12'b000000000100,
        S_PUSH   = 12'b000000001000,
        S_RSTART = 12'b000000010000,
        S_RWAIT  = 12'b000000100000,
        S_DIST   = 12'b000001000000,
        S_TERM   = 12'b000010000000,
        S_CMP    = 12'b000100000000,
        S_DONE   = 12'b001000000000,
        S_ULOAD  = 12'b010000000000,
        S_UWRITE = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    t_blk  blk_mem  [NUM_SETS*NUM_WAYS];
    logic [ADDR_BITS-1:0] hist_mem [NUM_SETS*HIST_DEPTH];
    t_meta meta_mem [NUM_SETS];

    logic [CNT_W-1:0]      r_wage, r_whit, r_wdist, r_wreuse, r_cap, r_lshift;
    logic [STAMP_BITS-1:0] r_clock;
    t_in_item              r_item;
    logic [BLK_W-1:0]      r_clr;
    logic [LOAD_CW-1:0]    r_cnt;
    t_blk                  r_blk_rd;
    logic [ADDR_BITS-1:0]  r_hist_rd;
    t_meta                 r_meta_rd;
    logic [STAMP_BITS-1:0] r_wstamp [NUM_WAYS];
    logic [CNT_W-1:0]      r_whits  [NUM_WAYS];
    logic [ADDR_BITS-1:0]  r_wpc    [NUM_WAYS];
    logic [ADDR_BITS-1:0]  r_waddr  [NUM_WAYS];
    logic [ADDR_BITS-1:0]  r_ring   [HIST_DEPTH];
    logic [FILL_W-1:0]     r_fill;
    logic [HIST_W-1:0]     r_head;
    logic [WAY_W-1:0]      r_w;
    logic [HIST_W-1:0]     r_k;
    logic [1:0]            r_ph;
    logic [SCORE_BITS-1:0] r_dist;
    logic [SCORE_BITS-1:0] r_score;
    logic [SCORE_BITS-1:0] r_best;
    logic [WAY_W-1:0]      r_win;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic [SET_W-1:0]      w_set;
    logic                  w_acc;
    logic                  w_load_out;
    logic [LOAD_CW-1:0]    w_cap_idx;
    logic [BLK_W-1:0]      w_blk_ra;
    logic                  w_blk_we;
    logic [BLK_W-1:0]      w_blk_wa;
    t_blk                  w_blk_wd;
    logic                  w_meta_we;
    logic [SET_W-1:0]      w_meta_wa;
    t_meta                 w_meta_wd;
    logic [FILL_W-1:0]     w_fill_nx;
    t_alu_req              w_alu_req;
    logic [SCORE_BITS-1:0] w_alu_res;
    logic [SCORE_BITS-1:0] w_term;
    logic [CNT_W-1:0]      w_weight;
    logic [STAMP_BITS-1:0] w_age;
    logic [CNT_W-1:0]      w_rterm;
    t_reuse_req            w_rreq;
    t_reuse_rsp            w_rsp;
    logic [NUM_WAYS-1:0]   w_found;
    logic [CNT_W-1:0]      w_fscore [NUM_WAYS];

    assign w_set      = r_item.set_index[SET_W-1:0];
    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_cap_idx  = LOAD_CW'(r_cnt - 1'b1);
    assign w_fill_nx  = (r_fill < FILL_W'(HIST_DEPTH)) ? r_fill + 1'b1 : r_fill;

    // memories
    always_comb begin
        w_blk_ra  = (r_state == S_LOAD) ? {w_set, r_cnt[WAY_W-1:0]}
                                        : {w_set, r_item.way_index[WAY_W-1:0]};
        w_blk_we  = (r_state == S_CLEAR) || (r_state == S_UWRITE);
        w_blk_wa  = (r_state == S_CLEAR) ? r_clr : {w_set, r_item.way_index[WAY_W-1:0]};
        if (r_state == S_CLEAR) begin
            w_blk_wd = '0;
        end else begin
            w_blk_wd.stamp = r_clock;
            w_blk_wd.hits  = hit_step(r_blk_rd.hits, r_item.was_hit, r_cap);
            w_blk_wd.pc    = r_item.program_counter;
            w_blk_wd.addr  = r_item.phys_addr;
        end
        w_meta_we = (r_state == S_CLEAR) || (r_state == S_PUSH);
        w_meta_wa = (r_state == S_CLEAR) ? r_clr[SET_W-1:0] : w_set;
        if (r_state == S_CLEAR) begin
            w_meta_wd = '0;
        end else begin
            w_meta_wd.fill = w_fill_nx;
            w_meta_wd.head = r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_blk_we) begin
            blk_mem[w_blk_wa] <= w_blk_wd;
        end
        r_blk_rd <= blk_mem[w_blk_ra];
        if (r_state == S_PUSH) begin
            hist_mem[{w_set, r_head}] <= r_item.phys_addr;
        end
        r_hist_rd <= hist_mem[{w_set, r_cnt[HIST_W-1:0]}];
        if (w_meta_we) begin
            meta_mem[w_meta_wa] <= w_meta_wd;
        end
        r_meta_rd <= meta_mem[w_set];
    end

    // shared arithmetic unit
    always_comb begin
        w_age   = r_clock - r_wstamp[r_w];
        w_rterm = w_found[r_w] ? cap_minus(w_fscore[r_w], r_cap) : r_cap;
        case (r_ph)
            2'd0: begin
                w_term   = SCORE_BITS'(w_age);
                w_weight = r_wage;
            end
            2'd1: begin
                w_term   = SCORE_BITS'(cap_minus(r_whits[r_w], r_cap));
                w_weight = r_whit;
            end
            2'd2: begin
                w_term   = r_dist >> r_lshift;
                w_weight = r_wdist;
            end
            default: begin
                w_term   = SCORE_BITS'(w_rterm);
                w_weight = r_wreuse;
            end
        endcase
        if (r_state == S_DIST) begin
            w_alu_req.op  = ALU_DIST;
            w_alu_req.a   = SCORE_BITS'(r_ring[r_k]);
            w_alu_req.b   = SCORE_BITS'(r_waddr[r_w]);
            w_alu_req.w   = '0;
            w_alu_req.acc = r_dist;
        end else begin
            w_alu_req.op  = ALU_MAC;
            w_alu_req.a   = w_term;
            w_alu_req.b   = '0;
            w_alu_req.w   = w_weight;
            w_alu_req.acc = (r_ph == 2'd0) ? '0 : r_score;
        end
    end

    wsc_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    always_comb begin
        w_rreq.clear   = (r_state == S_CLEAR);
        w_rreq.clr_idx = r_clr[REUSE_W-1:0];
        w_rreq.lookup  = (r_state == S_RSTART) && !r_item.mode;
        w_rreq.train   = (r_state == S_RSTART) && r_item.mode;
        w_rreq.hit     = r_item.was_hit;
        w_rreq.pc      = r_item.program_counter;
        w_rreq.clock   = r_clock;
        w_rreq.cap     = r_cap;
    end

    wsc_reuse u_reuse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rreq),
        .i_pcs   (r_wpc),
        .o_rsp   (w_rsp),
        .o_found (w_found),
        .o_score (w_fscore)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == BLK_W'(NUM_SETS*NUM_WAYS-1)) n_state = S_IDLE;
            S_IDLE:   if (w_acc) n_state = i_in_data.mode ? S_ULOAD : S_LOAD;
            S_LOAD:   if (r_cnt == LOAD_CW'(LOAD_N)) n_state = S_PUSH;
            S_PUSH:   n_state = S_RSTART;
            S_RSTART: n_state = S_RWAIT;
            S_RWAIT:  if (w_rsp.done) n_state = r_item.mode ? S_IDLE : S_DIST;
            S_DIST:   if (r_k == HIST_W'(HIST_DEPTH-1)) n_state = S_TERM;
            S_TERM:   if (r_ph == 2'd3) n_state = S_CMP;
            S_CMP:    n_state = (r_w == WAY_W'(NUM_WAYS-1)) ? S_DONE : S_DIST;
            S_DONE:   if (w_load_out) n_state = S_IDLE;
            S_ULOAD:  n_state = S_UWRITE;
            S_UWRITE: n_state = S_RSTART;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
            r_wage      <= 4'd2;
            r_whit      <= 4'd3;
            r_wdist     <= 4'd2;
            r_wreuse    <= 4'd3;
            r_cap       <= 4'd10;
            r_lshift    <= 4'd6;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WEIGHT_AGE:   r_wage   <= i_cfg_wdata;
                    CFG_WEIGHT_HITS:  r_whit   <= i_cfg_wdata;
                    CFG_WEIGHT_DIST:  r_wdist  <= i_cfg_wdata;
                    CFG_WEIGHT_REUSE: r_wreuse <= i_cfg_wdata;
                    CFG_COUNT_CAP:    r_cap    <= i_cfg_wdata;
                    CFG_LINE_SHIFT:   r_lshift <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_acc) begin
                r_clock <= r_clock + 1'b1;
                r_cnt   <= '0;
            end
            if (r_state == S_LOAD) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == S_LOAD && r_cnt != '0) begin
            if (w_cap_idx < LOAD_CW'(NUM_WAYS)) begin
                r_wstamp[w_cap_idx[WAY_W-1:0]] <= r_blk_rd.stamp;
                r_whits[w_cap_idx[WAY_W-1:0]]  <= r_blk_rd.hits;
                r_wpc[w_cap_idx[WAY_W-1:0]]    <= r_blk_rd.pc;
                r_waddr[w_cap_idx[WAY_W-1:0]]  <= r_blk_rd.addr;
            end
            if (w_cap_idx < LOAD_CW'(HIST_DEPTH)) begin
                r_ring[w_cap_idx[HIST_W-1:0]] <= r_hist_rd;
            end
            if (r_cnt == LOAD_CW'(1)) begin
                r_fill <= r_meta_rd.fill;
                r_head <= r_meta_rd.head;
            end
        end
        if (r_state == S_PUSH) begin
            r_ring[r_head] <= r_item.phys_addr;
            r_fill         <= w_fill_nx;
            r_w            <= '0;
        end
        if (r_state == S_RWAIT || r_state == S_CMP) begin
            r_k    <= '0;
            r_dist <= '1;
        end
        if (r_state == S_DIST) begin
            r_k  <= r_k + 1'b1;
            r_ph <= '0;
            if (FILL_W'(r_k) < r_fill) begin
                r_dist <= w_alu_res;
            end
        end
        if (r_state == S_TERM) begin
            r_ph    <= r_ph + 1'b1;
            r_score <= w_alu_res;
        end
        if (r_state == S_CMP) begin
            if (r_w == '0 || r_score > r_best) begin
                r_best <= r_score;
                r_win  <= r_w;
            end
            r_w <= r_w + 1'b1;
        end
        if (w_load_out) begin
            r_out.evict_way    <= 4'(r_win);
            r_out.victim_score <= r_best;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `WSC_ASSERT(a_done_only_waiting, w_rsp.done |-> (r_state == S_RWAIT), "done out of turn")
    `WSC_ASSERT(a_fill_range, (r_state == S_DIST) |-> (r_fill != '0), "ring fill empty")
    `WSC_ASSERT_NEXT(a_result_shown, w_load_out, o_out_valid, "result not presented")

endmodule

// File: sv/wsc_alu.sv
module wsc_alu import wsc_pkg::*; (
    input  t_alu_req              i_req,
    output logic [SCORE_BITS-1:0] o_res
);

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

    logic [SCORE_BITS+CNT_W-1:0] w_prod;
    logic [SCORE_BITS-1:0]       w_prod_sat;
    logic [SCORE_BITS:0]         w_sum;
    logic [SCORE_BITS-1:0]       w_diff;

    always_comb begin
        w_prod     = i_req.a * {{SCORE_BITS{1'b0}}, i_req.w};
        w_prod_sat = (w_prod[SCORE_BITS+CNT_W-1:SCORE_BITS] != '0) ? SCORE_MAX
                                                                 : w_prod[SCORE_BITS-1:0];
        w_sum      = {1'b0, i_req.acc} + {1'b0, w_prod_sat};
        w_diff     = (i_req.a > i_req.b) ? i_req.a - i_req.b : i_req.b - i_req.a;
        case (i_req.op)
            ALU_DIST: o_res = (w_diff < i_req.acc) ? w_diff : i_req.acc;
            ALU_MAC:  o_res = w_sum[SCORE_BITS] ? SCORE_MAX : w_sum[SCORE_BITS-1:0];
            default:  o_res = i_req.acc;
        endcase
    end

endmodule

// File: sv/wsc_reuse.sv
module wsc_reuse import wsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_reuse_req           i_req,
    input  logic [ADDR_BITS-1:0] i_pcs [NUM_WAYS],
    output t_reuse_rsp           o_rsp,
    output logic [NUM_WAYS-1:0]  o_found,
    output logic [CNT_W-1:0]     o_score [NUM_WAYS]
);

    t_reuse_ent mem [REUSE_ENTRIES];

    logic                  r_busy;
    logic                  r_train;
    logic                  r_wr;
    logic                  r_done;
    logic [REUSE_W:0]      r_idx;
    logic                  r_rd_vld;
    logic [REUSE_W-1:0]    r_rd_idx;
    t_reuse_ent            r_rd;
    logic                  r_match;
    logic [REUSE_W-1:0]    r_mslot;
    logic [CNT_W-1:0]      r_mscore;
    logic                  r_inv;
    logic [REUSE_W-1:0]    r_islot;
    logic [REUSE_W-1:0]    r_oslot;
    logic [STAMP_BITS-1:0] r_oage;
    logic [NUM_WAYS-1:0]   r_found;
    logic [CNT_W-1:0]      r_fscore [NUM_WAYS];

    logic                  w_we;
    logic [REUSE_W-1:0]    w_wa;
    t_reuse_ent            w_wd;
    logic [STAMP_BITS-1:0] w_age;
    logic [CNT_W-1:0]      w_base;
    logic                  w_scan_end;

    always_comb begin
        w_age      = i_req.clock - r_rd.stamp;
        w_base     = r_match ? r_mscore : '0;
        w_scan_end = r_busy && !r_wr && !r_rd_vld && (r_idx == (REUSE_W+1)'(REUSE_ENTRIES));
        w_we       = i_req.clear || r_wr;
        if (i_req.clear) begin
            w_wa = i_req.clr_idx;
            w_wd = '0;
        end else begin
            w_wa       = r_match ? r_mslot : (r_inv ? r_islot : r_oslot);
            w_wd.valid = 1'b1;
            w_wd.tag   = i_req.pc;
            w_wd.score = hit_step(w_base, i_req.hit, i_req.cap);
            w_wd.stamp = i_req.clock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd <= mem[r_idx[REUSE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_train  <= 1'b0;
            r_wr     <= 1'b0;
            r_done   <= 1'b0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_match  <= 1'b0;
            r_inv    <= 1'b0;
            r_found  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.lookup || i_req.train) begin
                    r_busy   <= 1'b1;
                    r_train  <= i_req.train;
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_match  <= 1'b0;
                    r_inv    <= 1'b0;
                    r_found  <= '0;
                end
            end else if (r_wr) begin
                r_wr   <= 1'b0;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (w_scan_end) begin
                if (r_train) begin
                    r_wr <= 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else begin
                if (r_idx != (REUSE_W+1)'(REUSE_ENTRIES)) begin
                    r_idx    <= r_idx + 1'b1;
                    r_rd_idx <= r_idx[REUSE_W-1:0];
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (r_rd_vld) begin
                    if (r_train) begin
                        if (!r_match && r_rd.valid && r_rd.tag == i_req.pc) begin
                            r_match  <= 1'b1;
                            r_mslot  <= r_rd_idx;
                            r_mscore <= r_rd.score;
                        end
                        if (!r_inv && !r_rd.valid) begin
                            r_inv   <= 1'b1;
                            r_islot <= r_rd_idx;
                        end
                        if (r_rd_idx == '0 || w_age > r_oage) begin
                            r_oage  <= w_age;
                            r_oslot <= r_rd_idx;
                        end
                    end else begin
                        for (int w = 0; w < NUM_WAYS; w++) begin
                            if (!r_found[w] && r_rd.valid && r_rd.tag == i_pcs[w]) begin
                                r_found[w]  <= 1'b1;
                                r_fscore[w] <= r_rd.score;
                            end
                        end
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_found    = r_found;
    assign o_score    = r_fscore;

endmodule

// File: tb/tb_weighted_score_cache_replacement_top.sv
module tb_weighted_score_cache_replacement_top import wsc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    class wsc_scoreboard;
        localparam logic [47:0] SCORE_TOP = 48'hFFFF_FFFF_FFFF;

        logic [3:0]  w_age, w_hits, w_dist, w_reuse, cap, shift;
        logic [31:0] now;
        logic [31:0] blk_stamp [NUM_SETS*NUM_WAYS];
        logic [3:0]  blk_hits  [NUM_SETS*NUM_WAYS];
        logic [47:0] blk_pc    [NUM_SETS*NUM_WAYS];
        logic [47:0] blk_addr  [NUM_SETS*NUM_WAYS];
        logic [47:0] ring      [NUM_SETS*HIST_DEPTH];
        logic [3:0]  ring_fill [NUM_SETS];
        logic [2:0]  ring_head [NUM_SETS];
        bit          pc_valid  [REUSE_ENTRIES];
        logic [47:0] pc_tag    [REUSE_ENTRIES];
        logic [3:0]  pc_rank   [REUSE_ENTRIES];
        logic [31:0] pc_stamp  [REUSE_ENTRIES];
        t_out_item   pending_victims [$];
        int          mismatches;
        int          victims, updates;

        function new();
            w_age = 2; w_hits = 3; w_dist = 2; w_reuse = 3; cap = 10; shift = 6;
            now = 0;
            foreach (blk_stamp[i]) begin
                blk_stamp[i] = 0; blk_hits[i] = 0; blk_pc[i] = 0; blk_addr[i] = 0;
            end
            foreach (ring[i]) ring[i] = 0;
            foreach (ring_fill[i]) begin
                ring_fill[i] = 0; ring_head[i] = 0;
            end
            foreach (pc_valid[i]) begin
                pc_valid[i] = 0; pc_tag[i] = 0; pc_rank[i] = 0; pc_stamp[i] = 0;
            end
            mismatches = 0; victims = 0; updates = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [3:0] v);
            case (idx)
                CFG_WEIGHT_AGE:   w_age = v;
                CFG_WEIGHT_HITS:  w_hits = v;
                CFG_WEIGHT_DIST:  w_dist = v;
                CFG_WEIGHT_REUSE: w_reuse = v;
                CFG_COUNT_CAP:    cap = v;
                CFG_LINE_SHIFT:   shift = v;
                default: ;
            endcase
        endfunction

        function logic [47:0] sat_mul(logic [47:0] a, logic [3:0] w);
            logic [63:0] p;
            p = 64'(a) * 64'(w);
            return (p > 64'(SCORE_TOP)) ? SCORE_TOP : p[47:0];
        endfunction

        function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? SCORE_TOP : s[47:0];
        endfunction

        function logic [3:0] headroom(logic [3:0] v);
            return (v >= cap) ? 4'd0 : cap - v;
        endfunction

        function logic [3:0] count_step(logic [3:0] v, bit hit);
            if (hit) return (v >= cap) ? cap : v + 4'd1;
            return (v == 0) ? 4'd0 : v - 4'd1;
        endfunction

        function int pc_lookup(logic [47:0] pc);
            for (int i = 0; i < REUSE_ENTRIES; i++)
                if (pc_valid[i] && pc_tag[i] == pc) return i;
            return -1;
        endfunction

        function void train_pc(logic [47:0] pc, bit hit);
            int slot;
            logic [31:0] oldest, age;
            slot = pc_lookup(pc);
            if (slot < 0) begin
                for (int i = 0; i < REUSE_ENTRIES; i++)
                    if (!pc_valid[i]) begin
                        slot = i;
                        break;
                    end
                if (slot < 0) begin
                    slot = 0;
                    oldest = now - pc_stamp[0];
                    for (int i = 1; i < REUSE_ENTRIES; i++) begin
                        age = now - pc_stamp[i];
                        if (age > oldest) begin
                            oldest = age; slot = i;
                        end
                    end
                end
                pc_valid[slot] = 1; pc_tag[slot] = pc; pc_rank[slot] = 0;
            end
            pc_stamp[slot] = now;
            pc_rank[slot] = count_step(pc_rank[slot], hit);
        endfunction

        function void note_item(t_in_item it);
            int base, b, e;
            logic [47:0] near, d, score, best, h;
            logic [3:0] rterm, win;
            t_out_item res;
            base = int'(it.set_index) * NUM_WAYS;
            now = now + 1;
            if (it.mode == 1'b0) begin
                victims++;
                ring[it.set_index*HIST_DEPTH + ring_head[it.set_index]] = it.phys_addr;
                ring_head[it.set_index] = ring_head[it.set_index] + 3'd1;
                if (ring_fill[it.set_index] < HIST_DEPTH) ring_fill[it.set_index]++;
                best = 0; win = 0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    b = base + w;
                    e = pc_lookup(blk_pc[b]);
                    rterm = (e < 0) ? cap : headroom(pc_rank[e]);
                    near = SCORE_TOP;
                    for (int k = 0; k < ring_fill[it.set_index]; k++) begin
                        h = ring[it.set_index*HIST_DEPTH + k];
                        d = (h > blk_addr[b]) ? h - blk_addr[b] : blk_addr[b] - h;
                        if (d < near) near = d;
                    end
                    near = near >> shift;
                    score = sat_mul(48'(now - blk_stamp[b]), w_age);
                    score = sat_add(score, sat_mul(48'(headroom(blk_hits[b])), w_hits));
                    score = sat_add(score, sat_mul(near, w_dist));
                    score = sat_add(score, sat_mul(48'(rterm), w_reuse));
                    if (w == 0 || score > best) begin
                        best = score; win = 4'(w);
                    end
                end
                res.evict_way = win;
                res.victim_score = best;
                pending_victims = {pending_victims, res};
            end else begin
                updates++;
                b = base + it.way_index;
                blk_stamp[b] = now;
                blk_addr[b] = it.phys_addr;
                blk_pc[b] = it.program_counter;
                blk_hits[b] = count_step(blk_hits[b], it.was_hit);
                train_pc(it.program_counter, it.was_hit);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_victims.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result way %0d score %0h", got.evict_way,
                             got.victim_score);
                return;
            end
            want = pending_victims.pop_front();
            if (got.evict_way !== want.evict_way || got.victim_score !== want.victim_score) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected way %0d score %0h, got way %0d score %0h",
                             want.evict_way, want.victim_score, got.evict_way,
                             got.victim_score);
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 0;
    t_out_item            o_out_data;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_wdata = '0;

    wsc_scoreboard victim_book = new();
    bit            calm;
    int            reg_writes;
    logic [47:0]   pc_pool [24];

    weighted_score_cache_replacement_top DUT (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    initial begin
        #80ms;
        $display("tb_weighted_score_cache_replacement_top: done, errors");
        $finish;
    end

    task automatic send_item(t_in_item it);
        int gap;
        bit taken;
        gap = calm ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge i_clk) i_in_valid = 0;
        @(negedge i_clk);
        i_in_valid = 1;
        i_in_data = it;
        forever begin
            #1 taken = o_in_ready;
            @(posedge i_clk);
            if (taken) break;
            @(negedge i_clk);
        end
        victim_book.note_item(it);
    endtask

    task automatic drain();
        @(negedge i_clk) i_in_valid = 0;
        while (victim_book.pending_victims.size() != 0) @(posedge i_clk);
        repeat (2400) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [3:0] v);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_wdata = v;
        victim_book.set_reg(idx, v);
        reg_writes++;
    endtask

    task automatic write_all(logic [3:0] wa, logic [3:0] wh, logic [3:0] wd,
                             logic [3:0] wr, logic [3:0] cp, logic [3:0] sh);
        write_reg(CFG_WEIGHT_AGE, wa);
        write_reg(CFG_WEIGHT_HITS, wh);
        write_reg(CFG_WEIGHT_DIST, wd);
        write_reg(CFG_WEIGHT_REUSE, wr);
        write_reg(CFG_COUNT_CAP, cp);
        write_reg(CFG_LINE_SHIFT, sh);
        @(negedge i_clk) i_cfg_we = 0;
    endtask

    function automatic t_in_item make_item(bit md, logic [10:0] s, logic [3:0] w,
                                           logic [47:0] a, logic [47:0] pc, bit hit);
        t_in_item it;
        it.mode = md; it.set_index = s; it.way_index = w;
        it.phys_addr = a; it.program_counter = pc; it.was_hit = hit;
        return it;
    endfunction

    function automatic logic [47:0] wide_rand();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic t_in_item random_item();
        logic [10:0] s;
        logic [47:0] a, pc;
        case ($urandom_range(0, 9))
            0, 1, 2: s = 0;
            3, 4:    s = 11'd2047;
            5, 6:    s = 11'd613;
            default: s = 11'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       a = 0;
            1:       a = 48'hFFFF_FFFF_FFFF;
            2, 3:    a = wide_rand();
            default: a = 48'h0000_4000_0000 + 48'($urandom_range(0, 65535));
        endcase
        pc = ($urandom_range(0, 5) == 0) ? wide_rand() : pc_pool[$urandom_range(0, 23)];
        return make_item($urandom_range(0, 9) < 6, s, 4'($urandom), a, pc,
                         $urandom_range(0, 1));
    endfunction

    initial begin
        bit got_it;
        t_out_item seen;
        wait (i_rst_n);
        forever begin
            repeat (calm ? 0 : $urandom_range(0, 7)) @(negedge i_clk) i_out_ready = 0;
            @(negedge i_clk) i_out_ready = 1;
            forever begin
                #1;
                got_it = o_out_valid;
                seen = o_out_data;
                @(posedge i_clk);
                if (got_it) break;
                @(negedge i_clk);
            end
            victim_book.check_result(seen);
        end
    end

    initial begin
        localparam logic [47:0] TOP = 48'hFFFF_FFFF_FFFF;
        foreach (pc_pool[i]) pc_pool[i] = (i == 0) ? 48'h0 : (i == 1) ? TOP : wide_rand();
        reg_writes = 0;
        calm = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;

        // directed part: reset scores, both extreme ends, repeated hits on one way and the PC at zero
        send_item(make_item(0, 0, 0, 0, 0, 0));
        send_item(make_item(1, 0, 0, TOP, 0, 1));
        send_item(make_item(1, 0, 4'd15, 48'h1000, TOP, 1));
        send_item(make_item(1, 0, 4'd15, 48'h1040, TOP, 1));
        send_item(make_item(1, 0, 4'd15, 48'h1080, TOP, 1));
        send_item(make_item(0, 0, 4'd9, TOP, TOP, 1));
        send_item(make_item(1, 0, 4'd3, 48'h2000, 0, 0));
        send_item(make_item(0, 0, 0, 48'h1000, 0, 0));
        send_item(make_item(1, 11'd2047, 4'd7, 0, 48'h5555_5555_5555, 0));
        send_item(make_item(0, 11'd2047, 4'd15, TOP, TOP, 1));
        send_item(make_item(0, 11'd2047, 0, 48'hAAAA_AAAA_AAAA, 0, 0));
        for (int i = 0; i < 9; i++) send_item(make_item(0, 11'd5, 0, 48'h40 * i, 0, 0));
        drain();

        write_all(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd0);
        send_item(make_item(0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 11'd2047, 0, TOP, 0, 0));
        drain();
        write_all(4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd12);
        send_item(make_item(0, 0, 0, TOP, 0, 0));
        send_item(make_item(1, 0, 4'd15, TOP, TOP, 0));

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: write_all(4'd2, 4'd3, 4'd2, 4'd3, 4'd10, 4'd6);
                1: write_all(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd0);
                2: write_all(4'd15, 4'd9, 4'd1, 4'd15, 4'd1, 4'd12);
                default: write_all(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                                   4'($urandom_range(1, 15)), 4'($urandom_range(0, 12)));
            endcase
            for (int n = 0; n < 256; n++) begin
                if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
                send_item(random_item());
            end
        end
        calm = 0;

        @(negedge i_clk) i_in_valid = 0;
        while (victim_book.pending_victims.size() != 0) @(posedge i_clk);
        repeat (2400) @(posedge i_clk);
        $display("covered %0d victim requests and %0d block updates over %0d register writes",
                 victim_book.victims, victim_book.updates, reg_writes);
        if (victim_book.mismatches == 0 && victim_book.pending_victims.size() == 0)
            $display("tb_weighted_score_cache_replacement_top: done, clean");
        else
            $display("tb_weighted_score_cache_replacement_top: done, errors");
        $finish;
    end
endmodule
